// ----- src/bst_pkg.sv -----
// Shared types and constants of the bencode stream tokenizer.
// Depends on nothing; imported by the tokenizer core.
package bst_pkg;

  typedef enum logic [2:0] {
    MODE_EXPECT,
    MODE_INT_SIGN,
    MODE_INT_DIG,
    MODE_STRLEN,
    MODE_BODY,
    MODE_DONE,
    MODE_STOPPED
  } mode_e;

  typedef enum logic [2:0] {
    TOK_INT  = 3'd0,
    TOK_STR  = 3'd1,
    TOK_LIST = 3'd2,
    TOK_DICT = 3'd3,
    TOK_END  = 3'd4,
    TOK_ERR  = 3'd5
  } tok_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_BAD_BYTE = 3'd1,
    ERR_OVERFLOW = 3'd2,
    ERR_TRUNC    = 3'd3,
    ERR_DEEP     = 3'd4
  } err_e;

  // One nesting level: bit 0 set for a dictionary, bit 1 set when a value is due.
  typedef logic [1:0] level_t;
  localparam int unsigned LV_DICT_BIT    = 0;
  localparam int unsigned LV_VALNEXT_BIT = 1;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_E     = 8'h65;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_I     = 8'h69;
  localparam logic [7:0] CHAR_L     = 8'h6c;
  localparam logic [7:0] CHAR_D     = 8'h64;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

endpackage

// ----- src/bst_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for the nesting stack of the tokenizer core.
module bst_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AddrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/bencode_stream_tokenizer_core.sv -----
// Bencode stream tokenizer: input beat register, one pass of parse logic, result register.
// An accepted beat passes the input beat and result registers to its token; throughput is
// one byte per cycle while m_axis_tready does not stall the result register.
// Reset (asynchronous, active low) empties both beat registers and clears the parse state;
// the nesting stack RAM needs no clearing pass.
// Depends on bst_pkg and bst_ram.
module bencode_stream_tokenizer_core
  import bst_pkg::*;
#(
  parameter int unsigned MAX_NEST_DEPTH = 32,
  parameter int unsigned INTEGER_WIDTH  = 64,
  parameter int unsigned OFFSET_WIDTH   = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] byte_value
  input  logic         s_axis_tuser,   // [0] first_byte
  input  logic         s_axis_tlast,   // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // [63:0] value, [95:64] start_offset,
                                       // [101:96] nest_level, [103:102] zero
  output logic [5:0]   m_axis_tuser,   // [2:0] token_kind, [5:3] error_kind
  output logic         m_axis_tlast    // complete
);

  localparam int unsigned AccWidth  = INTEGER_WIDTH - 1;
  localparam int unsigned SpWidth   = $clog2(MAX_NEST_DEPTH + 1);
  localparam int unsigned AddrWidth = (MAX_NEST_DEPTH > 1) ? $clog2(MAX_NEST_DEPTH) : 1;
  localparam logic [AccWidth-1:0] NumLimit =
      ({AccWidth{1'b1}} - AccWidth'(10)) / AccWidth'(10);
  localparam logic [SpWidth-1:0] SpMax = SpWidth'(MAX_NEST_DEPTH);

  // Input beat register.
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_first_q, in_last_q;

  // Result register.
  logic        out_valid_q, out_valid_d;
  tok_e        out_kind_q;
  logic [63:0] out_value_q;
  logic [31:0] out_start_q;
  logic [5:0]  out_level_q;
  logic        out_comp_q;
  err_e        out_err_q;

  // Parse state.
  mode_e                mode_q, mode_d;
  logic [AccWidth-1:0]  acc_q, acc_d;
  logic                 neg_q, neg_d;
  logic [AccWidth-1:0]  rem_q, rem_d;
  logic [SpWidth-1:0]   sp_q, sp_d;
  level_t               top_q, top_d;
  logic [OFFSET_WIDTH-1:0] off_q, off_d, ts_q, ts_d;

  // Stack RAM holds every level below the top; the top lives in top_q.
  logic                 ram_we;
  logic [AddrWidth-1:0] ram_waddr, ram_raddr;
  level_t               ram_rdata;
  logic                 byp_q;
  level_t               byp_data_q;
  level_t               below;

  logic advance, process;

  // Combinational results of one parse step.
  logic        tok;
  tok_e        tok_kind;
  logic [63:0] tok_value;
  logic [OFFSET_WIDTH-1:0] tok_start;
  logic        tok_comp;
  err_e        tok_err;
  logic [SpWidth-1:0] sp_n;

  assign advance       = !out_valid_q || m_axis_tready;
  assign process       = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_valid_d    = s_axis_tready ? s_axis_tvalid : in_valid_q;
  assign out_valid_d   = advance ? (process && tok) : out_valid_q;
  assign below         = byp_q ? byp_data_q : ram_rdata;
  assign ram_raddr     = AddrWidth'(sp_d - SpWidth'(2));

  bst_ram #(
    .WIDTH($bits(level_t)),
    .DEPTH(MAX_NEST_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(top_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    mode_e                   mode_c;
    logic [AccWidth-1:0]     acc_c, rem_c, rem_dec;
    logic                    neg_c;
    logic [SpWidth-1:0]      sp_c;
    logic [OFFSET_WIDTH-1:0] off_c, ts_c;
    level_t                  top_c;
    logic                    in_dict, want_key, is_digit, digit, colon, fin, push;
    logic [3:0]              dval;

    // A first byte starts from cleared state.
    mode_c = in_first_q ? MODE_EXPECT : mode_q;
    acc_c  = in_first_q ? '0 : acc_q;
    neg_c  = in_first_q ? 1'b0 : neg_q;
    rem_c  = in_first_q ? '0 : rem_q;
    sp_c   = in_first_q ? '0 : sp_q;
    off_c  = in_first_q ? '0 : off_q;
    ts_c   = in_first_q ? '0 : ts_q;
    top_c  = top_q;

    sp_n      = sp_c;
    mode_d    = mode_c;
    acc_d     = acc_c;
    neg_d     = neg_c;
    rem_d     = rem_c;
    ts_d      = ts_c;
    top_d     = top_c;
    off_d     = off_c + OFFSET_WIDTH'(1);
    tok       = 1'b0;
    tok_kind  = TOK_INT;
    tok_value = '0;
    tok_start = off_c;
    tok_comp  = 1'b0;
    tok_err   = ERR_NONE;
    digit     = 1'b0;
    colon     = 1'b0;
    fin       = 1'b0;
    push      = 1'b0;
    rem_dec   = rem_c - AccWidth'(1);
    dval      = in_byte_q[3:0];
    is_digit  = (in_byte_q >= CHAR_ZERO) && (in_byte_q <= CHAR_NINE);
    in_dict   = (sp_c != '0) && top_c[LV_DICT_BIT];
    want_key  = in_dict && !top_c[LV_VALNEXT_BIT];

    unique case (mode_c)
      MODE_EXPECT: begin
        if (in_byte_q == CHAR_E && sp_c != '0 && !(in_dict && top_c[LV_VALNEXT_BIT])) begin
          sp_n     = sp_c - SpWidth'(1);
          top_d    = below;
          tok      = 1'b1;
          tok_kind = TOK_END;
          fin      = 1'b1;
        end else if (want_key) begin
          if (is_digit) begin
            ts_d   = off_c;
            acc_d  = AccWidth'(dval);
            mode_d = MODE_STRLEN;
          end else if (in_byte_q == CHAR_COLON) begin
            ts_d  = off_c;
            acc_d = '0;
            colon = 1'b1;
          end else begin
            tok_err = ERR_BAD_BYTE;
          end
        end else if (in_byte_q == CHAR_L || in_byte_q == CHAR_D) begin
          if (sp_c >= SpMax) begin
            tok_err = ERR_DEEP;
          end else begin
            push  = 1'b1;
            sp_n  = sp_c + SpWidth'(1);
            top_d = '0;
            top_d[LV_DICT_BIT] = (in_byte_q == CHAR_D);
            tok      = 1'b1;
            tok_kind = (in_byte_q == CHAR_D) ? TOK_DICT : TOK_LIST;
          end
        end else if (in_byte_q == CHAR_I) begin
          ts_d   = off_c;
          acc_d  = '0;
          neg_d  = 1'b0;
          mode_d = MODE_INT_SIGN;
        end else if (is_digit) begin
          ts_d   = off_c;
          acc_d  = AccWidth'(dval);
          mode_d = MODE_STRLEN;
        end else begin
          tok_err = ERR_BAD_BYTE;
        end
      end
      MODE_INT_SIGN, MODE_INT_DIG: begin
        if (mode_c == MODE_INT_SIGN && in_byte_q == CHAR_MINUS) begin
          neg_d  = 1'b1;
          mode_d = MODE_INT_DIG;
        end else if (in_byte_q == CHAR_E) begin
          tok       = 1'b1;
          tok_kind  = TOK_INT;
          tok_start = ts_c;
          tok_value = neg_c ? (64'd0 - 64'(acc_c)) : 64'(acc_c);
          fin       = 1'b1;
        end else if (is_digit) begin
          mode_d = MODE_INT_DIG;
          digit  = 1'b1;
        end else begin
          tok_err = ERR_BAD_BYTE;
        end
      end
      MODE_STRLEN: begin
        if (in_byte_q == CHAR_COLON) begin
          colon = 1'b1;
        end else if (is_digit) begin
          digit = 1'b1;
        end else begin
          tok_err = ERR_BAD_BYTE;
        end
      end
      MODE_BODY: begin
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          mode_d = (sp_c == '0) ? MODE_DONE : MODE_EXPECT;
        end
      end
      default: begin
      end
    endcase

    if (digit) begin
      if (acc_c >= NumLimit) begin
        tok_err = ERR_OVERFLOW;
      end else begin
        acc_d = (acc_c << 3) + (acc_c << 1) + AccWidth'(dval);
      end
    end

    if (colon) begin
      rem_d     = acc_d;
      tok       = 1'b1;
      tok_kind  = TOK_STR;
      tok_value = 64'(acc_d);
      tok_start = ts_d;
      fin       = 1'b1;
    end

    // The value at the current level has ended.
    if (fin) begin
      tok_comp = (sp_n == '0);
      if (sp_n != '0 && top_d[LV_DICT_BIT]) begin
        top_d[LV_VALNEXT_BIT] = !top_d[LV_VALNEXT_BIT];
      end
      if (colon && acc_d != '0) begin
        mode_d = MODE_BODY;
      end else begin
        mode_d = tok_comp ? MODE_DONE : MODE_EXPECT;
      end
    end

    if (tok_err == ERR_NONE && in_last_q && mode_d != MODE_DONE && mode_d != MODE_STOPPED) begin
      tok_err = ERR_TRUNC;
    end
    if (tok_err != ERR_NONE) begin
      mode_d    = MODE_STOPPED;
      tok       = 1'b1;
      tok_kind  = TOK_ERR;
      tok_value = '0;
      tok_start = off_c;
      tok_comp  = 1'b0;
    end

    ram_we    = process && push && (sp_c != '0);
    ram_waddr = AddrWidth'(sp_c - SpWidth'(1));
    sp_d      = process ? sp_n : sp_q;

    if (!process) begin
      mode_d = mode_q;
      acc_d  = acc_q;
      neg_d  = neg_q;
      rem_d  = rem_q;
      ts_d   = ts_q;
      top_d  = top_q;
      off_d  = off_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_EXPECT;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      rem_q       <= '0;
      sp_q        <= '0;
      top_q       <= '0;
      off_q       <= '0;
      ts_q        <= '0;
      byp_q       <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      mode_q      <= mode_d;
      acc_q       <= acc_d;
      neg_q       <= neg_d;
      rem_q       <= rem_d;
      sp_q        <= sp_d;
      top_q       <= top_d;
      off_q       <= off_d;
      ts_q        <= ts_d;
      byp_q       <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= top_q;
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q  <= s_axis_tdata;
      in_first_q <= s_axis_tuser;
      in_last_q  <= s_axis_tlast;
    end
    if (process && tok && advance) begin
      out_kind_q  <= tok_kind;
      out_value_q <= tok_value;
      out_start_q <= 32'(tok_start);
      out_level_q <= 6'(sp_n);
      out_comp_q  <= tok_comp;
      out_err_q   <= tok_err;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_level_q, out_start_q, out_value_q};
  assign m_axis_tuser  = {out_err_q, out_kind_q};
  assign m_axis_tlast  = out_comp_q;

endmodule

// ----- dv/bencode_stream_tokenizer_core_tb.sv -----
// Self-checking testbench for bencode_stream_tokenizer_core: byte beats in, token beats out.
// A cycle-free token predictor runs on every accepted byte, and a checker matches each
// token beat in order; depends on bst_pkg and the tokenizer core RTL.
module bencode_stream_tokenizer_core_tb;
  import bst_pkg::*;

  localparam int unsigned MAX_DEPTH    = 32;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 150000;
  localparam int unsigned RANDOM_BYTES = 870;
  localparam logic [63:0] NUM_LIMIT    = (64'h7FFF_FFFF_FFFF_FFFF - 64'd10) / 64'd10;

  typedef struct packed {
    tok_e        kind;
    err_e        err;
    logic        complete;
    logic [5:0]  level;
    logic [31:0] start;
    logic [63:0] value;
  } token_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_style_e;

  logic          clk_i;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [7:0]    s_axis_tdata;
  logic          s_axis_tuser;
  logic          s_axis_tlast;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [103:0]  m_axis_tdata;
  logic [5:0]    m_axis_tuser;
  logic          m_axis_tlast;

  bencode_stream_tokenizer_core dut (.*);

  // Predicted parser state.
  mode_e       pm;
  logic [63:0] acc;
  logic        neg;
  logic [63:0] body_left;
  level_t      lvl [MAX_DEPTH];
  int unsigned depth;
  logic [31:0] offs;
  logic [31:0] tok_start;

  token_t      pending_tokens[$];
  logic [7:0]  doc_bytes[$];
  int unsigned fail_count;
  int unsigned hold_requests;
  int unsigned burst_left;
  bit          idle_sender;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit is_digit(logic [7:0] b);
    return b >= CHAR_ZERO && b <= CHAR_NINE;
  endfunction

  function automatic void clear_parse();
    pm = MODE_EXPECT;
    acc = '0;
    neg = 1'b0;
    body_left = '0;
    depth = 0;
    offs = '0;
    tok_start = '0;
    foreach (lvl[i]) lvl[i] = '0;
  endfunction

  function automatic logic close_value();
    if (depth == 0) return 1'b1;
    if (lvl[depth - 1][LV_DICT_BIT])
      lvl[depth - 1][LV_VALNEXT_BIT] = ~lvl[depth - 1][LV_VALNEXT_BIT];
    return 1'b0;
  endfunction

  function automatic bit tokenize_byte(input logic [7:0] b, input bit first, input bit last,
                                       output token_t t);
    logic [31:0] at;
    level_t      top;
    bit          in_dict, want_key, tok, colon, digit;
    err_e        err;
    t = '0;
    tok = 1'b0;
    colon = 1'b0;
    digit = 1'b0;
    err = ERR_NONE;
    if (first) clear_parse();
    at = offs;
    offs = offs + 32'd1;
    case (pm)
      MODE_EXPECT: begin
        top = (depth != 0) ? lvl[depth - 1] : '0;
        in_dict = (depth != 0) && top[LV_DICT_BIT];
        want_key = in_dict && !top[LV_VALNEXT_BIT];
        if (b == CHAR_E && depth != 0 && !(in_dict && top[LV_VALNEXT_BIT])) begin
          depth--;
          tok = 1'b1;
          t.kind = TOK_END;
          t.start = at;
          t.complete = close_value();
          pm = t.complete ? MODE_DONE : MODE_EXPECT;
        end else if (want_key) begin
          if (is_digit(b)) begin
            tok_start = at;
            acc = {56'd0, b - CHAR_ZERO};
            pm = MODE_STRLEN;
          end else if (b == CHAR_COLON) begin
            tok_start = at;
            acc = '0;
            colon = 1'b1;
          end else begin
            err = ERR_BAD_BYTE;
          end
        end else if (b == CHAR_L || b == CHAR_D) begin
          if (depth >= MAX_DEPTH) begin
            err = ERR_DEEP;
          end else begin
            lvl[depth] = '0;
            lvl[depth][LV_DICT_BIT] = (b == CHAR_D);
            depth++;
            tok = 1'b1;
            t.kind = (b == CHAR_D) ? TOK_DICT : TOK_LIST;
            t.start = at;
          end
        end else if (b == CHAR_I) begin
          tok_start = at;
          acc = '0;
          neg = 1'b0;
          pm = MODE_INT_SIGN;
        end else if (is_digit(b)) begin
          tok_start = at;
          acc = {56'd0, b - CHAR_ZERO};
          pm = MODE_STRLEN;
        end else begin
          err = ERR_BAD_BYTE;
        end
      end
      MODE_INT_SIGN, MODE_INT_DIG: begin
        if (pm == MODE_INT_SIGN && b == CHAR_MINUS) begin
          neg = 1'b1;
          pm = MODE_INT_DIG;
        end else if (b == CHAR_E) begin
          tok = 1'b1;
          t.kind = TOK_INT;
          t.start = tok_start;
          t.value = neg ? (64'd0 - acc) : acc;
          t.complete = close_value();
          pm = t.complete ? MODE_DONE : MODE_EXPECT;
        end else if (is_digit(b)) begin
          pm = MODE_INT_DIG;
          digit = 1'b1;
        end else begin
          err = ERR_BAD_BYTE;
        end
      end
      MODE_STRLEN: begin
        if (b == CHAR_COLON) colon = 1'b1;
        else if (is_digit(b)) digit = 1'b1;
        else err = ERR_BAD_BYTE;
      end
      MODE_BODY: begin
        if (body_left != 0) body_left = body_left - 64'd1;
        if (body_left == 0) pm = (depth == 0) ? MODE_DONE : MODE_EXPECT;
      end
      default: begin
      end
    endcase
    if (digit) begin
      if (acc >= NUM_LIMIT) err = ERR_OVERFLOW;
      else acc = acc * 64'd10 + {56'd0, b - CHAR_ZERO};
    end
    if (colon) begin
      body_left = acc;
      tok = 1'b1;
      t.kind = TOK_STR;
      t.value = acc;
      t.start = tok_start;
      t.complete = close_value();
      if (body_left != 0) pm = MODE_BODY;
      else pm = t.complete ? MODE_DONE : MODE_EXPECT;
    end
    if (err == ERR_NONE && last && pm != MODE_DONE && pm != MODE_STOPPED) err = ERR_TRUNC;
    if (err != ERR_NONE) begin
      pm = MODE_STOPPED;
      tok = 1'b1;
      t.kind = TOK_ERR;
      t.value = '0;
      t.start = at;
      t.complete = 1'b0;
    end
    t.err = err;
    t.level = 6'(depth);
    return tok;
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit first, input bit last);
    token_t tk;
    if (burst_left == 0) begin
      if (idle_sender) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (tokenize_byte(b, first, last, tk)) pending_tokens.push_back(tk);
  endtask

  task automatic play_doc(input bit start_new, input bit mark_end);
    for (int i = 0; i < doc_bytes.size(); i++)
      push_byte(doc_bytes[i], start_new && i == 0, mark_end && i == doc_bytes.size() - 1);
    doc_bytes.delete();
  endtask

  function automatic void put(string s);
    for (int i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
  endfunction

  task automatic run_doc(input string s, input bit start_new, input bit mark_end);
    put(s);
    play_doc(start_new, mark_end);
  endtask

  function automatic void emit_string();
    int unsigned len;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5);
    if ($urandom_range(0, 9) == 0) doc_bytes.push_back(CHAR_ZERO);
    if (len >= 10) doc_bytes.push_back(CHAR_ZERO + 8'(len / 10));
    doc_bytes.push_back(CHAR_ZERO + 8'(len % 10));
    doc_bytes.push_back(CHAR_COLON);
    repeat (len) doc_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void gen_doc(int unsigned max_nest);
    bit          dict_q[$];
    int unsigned left_q[$];
    bit          key_q[$];
    bit          want_value, is_dict;
    int unsigned top, ndig, pick;
    want_value = 1'b1;
    while (want_value || dict_q.size() != 0) begin
      if (want_value) begin
        want_value = 1'b0;
        if (dict_q.size() < max_nest && $urandom_range(0, 9) < 4) begin
          is_dict = 1'($urandom_range(0, 1));
          doc_bytes.push_back(is_dict ? CHAR_D : CHAR_L);
          dict_q.push_back(is_dict);
          left_q.push_back($urandom_range(0, 3));
          key_q.push_back(is_dict);
        end else if ($urandom_range(0, 1) == 0) begin
          emit_string();
        end else begin
          doc_bytes.push_back(CHAR_I);
          if ($urandom_range(0, 3) == 0) doc_bytes.push_back(CHAR_MINUS);
          ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 21) : $urandom_range(0, 4);
          repeat (ndig) doc_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
          doc_bytes.push_back(CHAR_E);
        end
      end else begin
        top = dict_q.size() - 1;
        if (left_q[top] == 0) begin
          doc_bytes.push_back(CHAR_E);
          void'(dict_q.pop_back());
          void'(left_q.pop_back());
          void'(key_q.pop_back());
        end else if (key_q[top]) begin
          key_q[top] = 1'b0;
          pick = $urandom_range(0, 29);
          if (pick == 0) doc_bytes.push_back(CHAR_L);
          else if (pick < 3) doc_bytes.push_back(CHAR_COLON);
          else emit_string();
        end else begin
          left_q[top] = left_q[top] - 1;
          key_q[top] = dict_q[top];
          want_value = 1'b1;
        end
      end
    end
  endfunction

  task automatic test_scalars();
    run_doc("ie", 1'b0, 1'b1);
    run_doc("i-e", 1'b1, 1'b1);
    run_doc("i-0042e", 1'b1, 1'b1);
    put("3:");
    doc_bytes.push_back(8'h00);
    doc_bytes.push_back(8'hFF);
    put("xi1e");
    play_doc(1'b1, 1'b1);
    run_doc("0:", 1'b1, 1'b1);
  endtask

  task automatic test_containers();
    run_doc("li1ed0:le1:ad:i-7eeee", 1'b1, 1'b1);
    run_doc("le", 1'b1, 1'b0);
    run_doc("de", 1'b1, 1'b1);
  endtask

  task automatic test_dict_keys();
    run_doc("di5ee", 1'b1, 1'b1);
    run_doc("d1:ae", 1'b1, 1'b1);
    run_doc("d:0:e", 1'b1, 1'b1);
    run_doc("dle", 1'b1, 1'b1);
  endtask

  task automatic test_bad_bytes();
    doc_bytes.push_back(8'h00);
    play_doc(1'b1, 1'b1);
    doc_bytes.push_back(8'hFF);
    play_doc(1'b1, 1'b1);
    run_doc(":", 1'b1, 1'b1);
    run_doc("e", 1'b1, 1'b1);
    run_doc("i1xi2e", 1'b1, 1'b1);
    run_doc("i--1e", 1'b1, 1'b1);
    run_doc("1a", 1'b1, 1'b1);
  endtask

  task automatic test_number_limits();
    run_doc("i-9223372036854775789e", 1'b1, 1'b1);
    run_doc("i9223372036854775790e", 1'b1, 1'b1);
    run_doc("9223372036854775800:", 1'b1, 1'b1);
  endtask

  task automatic test_nesting_depth();
    repeat (MAX_DEPTH) doc_bytes.push_back(CHAR_L);
    put("i0e");
    repeat (MAX_DEPTH) doc_bytes.push_back(CHAR_E);
    play_doc(1'b1, 1'b1);
    repeat (MAX_DEPTH) doc_bytes.push_back(CHAR_L);
    put("d");
    play_doc(1'b1, 1'b1);
  endtask

  task automatic test_truncation();
    run_doc("li1e", 1'b1, 1'b1);
    run_doc("i12", 1'b1, 1'b1);
    run_doc("5:ab", 1'b1, 1'b1);
    run_doc("d1:a", 1'b1, 1'b1);
    run_doc("l", 1'b1, 1'b1);
  endtask

  task automatic test_restart();
    run_doc("li1e", 1'b1, 1'b0);
    run_doc("i2e", 1'b1, 1'b1);
    run_doc("3:ab", 1'b1, 1'b0);
    run_doc("i5e", 1'b1, 1'b1);
  endtask

  task automatic test_output_stall();
    idle_sender = 1'b0;
    hold_requests++;
    put("l");
    for (int k = 0; k < 40; k++) put($sformatf("i%0de", k));
    put("e");
    play_doc(1'b1, 1'b1);
    idle_sender = 1'b1;
  endtask

  task automatic test_random_docs();
    int unsigned sent, shape, n;
    bit          start_new, mark_end;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      start_new = $urandom_range(0, 19) != 0;
      mark_end = $urandom_range(0, 3) != 0;
      idle_sender = $urandom_range(0, 4) != 0;
      shape = $urandom_range(0, 19);
      if (shape < 2) begin
        repeat ($urandom_range(1, 6)) doc_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (shape < 4) begin
        n = $urandom_range(MAX_DEPTH - 4, MAX_DEPTH + 2);
        repeat (n) doc_bytes.push_back(CHAR_L);
        gen_doc(2);
        repeat (n) doc_bytes.push_back(CHAR_E);
      end else begin
        gen_doc($urandom_range(1, 4));
        if (shape < 6) begin
          doc_bytes[$urandom_range(0, doc_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (shape < 8) begin
          n = $urandom_range(1, doc_bytes.size());
          while (doc_bytes.size() > n) void'(doc_bytes.pop_back());
          mark_end = 1'b1;
        end else if (shape < 10) begin
          repeat ($urandom_range(1, 3)) doc_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
      sent += doc_bytes.size();
      play_doc(start_new, mark_end);
    end
  endtask

  function automatic string describe(token_t t);
    return $sformatf("kind %0d err %0d value %h start %0d level %0d complete %0b",
                     t.kind, t.err, t.value, t.start, t.level, t.complete);
  endfunction

  function automatic void log_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk_i) begin : token_check
    token_t seen, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.kind = tok_e'(m_axis_tuser[2:0]);
      seen.err = err_e'(m_axis_tuser[5:3]);
      seen.value = m_axis_tdata[63:0];
      seen.start = m_axis_tdata[95:64];
      seen.level = m_axis_tdata[101:96];
      seen.complete = m_axis_tlast;
      if (pending_tokens.size() == 0) begin
        log_failure($sformatf("unexpected token: %s", describe(seen)));
      end else begin
        want = pending_tokens.pop_front();
        if (seen.kind !== want.kind || seen.err !== want.err ||
            seen.value !== want.value || seen.start !== want.start ||
            seen.level !== want.level || seen.complete !== want.complete)
          log_failure($sformatf("token mismatch: expected %s, got %s",
                                describe(want), describe(seen)));
      end
    end
  end

  initial begin : rx_side
    rx_style_e   style;
    int unsigned style_left, phase, hold_served;
    style = RX_ALWAYS;
    style_left = 0;
    phase = 0;
    hold_served = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_requests) begin
        m_axis_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
        hold_served++;
      end else begin
        if (style_left == 0) begin
          style = rx_style_e'($urandom_range(0, 3));
          style_left = $urandom_range(20, 80);
        end
        style_left--;
        phase++;
        case (style)
          RX_ALWAYS: m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_axis_tready <= (phase % 4 == 0);
          default:   m_axis_tready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : main
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    s_axis_tlast  <= 1'b0;
    fail_count = 0;
    hold_requests = 0;
    burst_left = 0;
    idle_sender = 1'b1;
    clear_parse();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_scalars();
    test_containers();
    test_dict_keys();
    test_bad_bytes();
    test_number_limits();
    test_nesting_depth();
    test_truncation();
    test_restart();
    test_output_stall();
    test_random_docs();
    s_axis_tvalid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/bst_pkg.sv
src/bst_ram.sv
src/bencode_stream_tokenizer_core.sv
dv/bencode_stream_tokenizer_core_tb.sv
